[design/fcst_pkg.sv]
// Shared types and constants for the FAST-12 segment test block.
// Used by every module in this folder; depends on nothing.
package fcst_pkg;

  localparam int RingSize  = 16;
  localparam int IdxW      = 4;
  localparam int PixW      = 8;
  localparam int DiffW     = PixW + 1;
  localparam int ScoreW    = 13;
  localparam int CompassN  = 4;

  // Compass positions in cyclic order
  localparam logic [IdxW-1:0] CompassPos [CompassN] = '{4'd13, 4'd1, 4'd5, 4'd9};

  typedef logic [PixW-1:0]          pix_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ScoreW-1:0] score_t;

  // What one start lane finds for its arc
  typedef struct packed {
    logic   all_above;
    logic   all_below;
    score_t sum_lo;
    score_t sum_hi;
  } lane_t;

endpackage

[design/fast_corner_segment_test.sv]
// FAST-12 segment test top level: three register stages with stall handling.
// Depends on fcst_pkg, fcst_classify, fcst_arc_lane and fcst_merge.
//
// Takes one pixel window per clock while the output is taken and returns one
// score per window. Sixteen classify lanes register differences and classes;
// sixteen arc lanes, one per start position, register arc matches and half
// sums; the merge stage runs the compass prescreen, picks the lowest matching
// start and adds its halves into the output register. Each stage takes a new
// item whenever it is empty or its successor moves, so the block sustains one
// item per cycle while the output is taken. The threshold is set through
// cfg_we_i/cfg_wdata_i, resets to 10, and should be written only while no item
// is in flight.
module fast_corner_segment_test #(
  parameter int ARC_LENGTH = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] center_pixel, [71:8] ring_first_half, [135:72] ring_second_half
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [12:0] corner_score, [13] is_corner, [14] prescreen_pass, [15] zero
  output logic [15:0]  m_axis_tdata
);

  localparam int Ring = fcst_pkg::RingSize;

  fcst_pkg::pix_t thr_q;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  fcst_pkg::diff_t [Ring-1:0] diff_d, diff1_q;
  logic [Ring-1:0]            above_d, above1_q, above2_q;
  logic [Ring-1:0]            below_d, below1_q, below2_q;
  fcst_pkg::lane_t [Ring-1:0] lane_d, lane2_q;

  fcst_pkg::score_t score_d, score_q;
  logic             corner_d, corner_q;
  logic             pre_d, pre_q;

  // each stage advances when empty or when its successor advances
  assign en3           = !v3_q || m_axis_tready;
  assign en2           = !v2_q || en3;
  assign en1           = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= fcst_pkg::PixW'(10);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  for (genvar k = 0; k < Ring; k++) begin : g_class
    fcst_classify u_class (
      .pixel_i  (s_axis_tdata[fcst_pkg::PixW*(k+1) +: fcst_pkg::PixW]),
      .center_i (s_axis_tdata[fcst_pkg::PixW-1:0]),
      .thr_i    (thr_q),
      .diff_o   (diff_d[k]),
      .above_o  (above_d[k]),
      .below_o  (below_d[k])
    );
  end

  for (genvar s = 0; s < Ring; s++) begin : g_lane
    fcst_arc_lane #(
      .START      (s),
      .ARC_LENGTH (ARC_LENGTH)
    ) u_lane (
      .above_i (above1_q),
      .below_i (below1_q),
      .diff_i  (diff1_q),
      .lane_o  (lane_d[s])
    );
  end

  fcst_merge u_merge (
    .lane_i      (lane2_q),
    .above_i     (above2_q),
    .below_i     (below2_q),
    .score_o     (score_d),
    .is_corner_o (corner_d),
    .pre_o       (pre_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      diff1_q  <= diff_d;
      above1_q <= above_d;
      below1_q <= below_d;
    end
    if (en2) begin
      lane2_q  <= lane_d;
      above2_q <= above1_q;
      below2_q <= below1_q;
    end
    if (en3) begin
      score_q  <= score_d;
      corner_q <= corner_d;
      pre_q    <= pre_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {1'b0, pre_q, corner_q, score_q};

endmodule

[design/fcst_classify.sv]
// One ring pixel: signed difference to the centre and its class.
// Depends on fcst_pkg.
module fcst_classify (
  input  fcst_pkg::pix_t  pixel_i,
  input  fcst_pkg::pix_t  center_i,
  input  fcst_pkg::pix_t  thr_i,
  output fcst_pkg::diff_t diff_o,
  output logic            above_o,
  output logic            below_o
);

  logic signed [fcst_pkg::DiffW:0] diff_ext;
  logic signed [fcst_pkg::DiffW:0] thr_ext;
  logic signed [fcst_pkg::DiffW:0] low_sum;

  always_comb begin
    diff_o   = $signed({1'b0, pixel_i}) - $signed({1'b0, center_i});
    diff_ext = (fcst_pkg::DiffW + 1)'(diff_o);
    thr_ext  = $signed({2'b00, thr_i});
    low_sum  = diff_ext + thr_ext;
    above_o  = diff_ext > thr_ext;
    // below when diff < -thr, i.e. diff + thr negative
    below_o  = low_sum[fcst_pkg::DiffW];
  end

endmodule

[design/fcst_arc_lane.sv]
// One arc start position: class match over the arc and its split difference sum.
// Depends on fcst_pkg.
module fcst_arc_lane #(
  parameter int START      = 0,
  parameter int ARC_LENGTH = 12
) (
  input  logic [fcst_pkg::RingSize-1:0]                  above_i,
  input  logic [fcst_pkg::RingSize-1:0]                  below_i,
  input  fcst_pkg::diff_t [fcst_pkg::RingSize-1:0]       diff_i,
  output fcst_pkg::lane_t                                lane_o
);

  localparam int LoLen = ARC_LENGTH / 2;
  localparam int HiLen = ARC_LENGTH - LoLen;

  logic [fcst_pkg::IdxW-1:0] idx_lo;
  logic [fcst_pkg::IdxW-1:0] idx_hi;

  always_comb begin
    lane_o.all_above = 1'b1;
    lane_o.all_below = 1'b1;
    lane_o.sum_lo    = '0;
    lane_o.sum_hi    = '0;
    idx_lo           = '0;
    idx_hi           = '0;
    for (int k = 0; k < LoLen; k++) begin
      idx_lo = fcst_pkg::IdxW'(START + k);
      lane_o.all_above = lane_o.all_above & above_i[idx_lo];
      lane_o.all_below = lane_o.all_below & below_i[idx_lo];
      lane_o.sum_lo    = lane_o.sum_lo + fcst_pkg::ScoreW'(diff_i[idx_lo]);
    end
    for (int k = 0; k < HiLen; k++) begin
      idx_hi = fcst_pkg::IdxW'(START + LoLen + k);
      lane_o.all_above = lane_o.all_above & above_i[idx_hi];
      lane_o.all_below = lane_o.all_below & below_i[idx_hi];
      lane_o.sum_hi    = lane_o.sum_hi + fcst_pkg::ScoreW'(diff_i[idx_hi]);
    end
  end

endmodule

[design/fcst_merge.sv]
// Merge of the start lanes: compass prescreen, first matching start, final score.
// Depends on fcst_pkg.
module fcst_merge (
  input  fcst_pkg::lane_t [fcst_pkg::RingSize-1:0] lane_i,
  input  logic [fcst_pkg::RingSize-1:0]            above_i,
  input  logic [fcst_pkg::RingSize-1:0]            below_i,
  output fcst_pkg::score_t                         score_o,
  output logic                                     is_corner_o,
  output logic                                     pre_o
);

  logic [fcst_pkg::CompassN-1:0] cmp_above;
  logic [fcst_pkg::CompassN-1:0] cmp_below;
  logic                          found;
  fcst_pkg::score_t              sel_lo;
  fcst_pkg::score_t              sel_hi;

  always_comb begin
    for (int c = 0; c < fcst_pkg::CompassN; c++) begin
      cmp_above[c] = above_i[fcst_pkg::CompassPos[c]];
      cmp_below[c] = below_i[fcst_pkg::CompassPos[c]];
    end
    pre_o = 1'b0;
    for (int c = 0; c < fcst_pkg::CompassN; c++) begin
      pre_o = pre_o
            | (cmp_above[c] & cmp_above[(c + 1) % fcst_pkg::CompassN]
               & cmp_above[(c + 2) % fcst_pkg::CompassN])
            | (cmp_below[c] & cmp_below[(c + 1) % fcst_pkg::CompassN]
               & cmp_below[(c + 2) % fcst_pkg::CompassN]);
    end

    // lowest start wins: scan down so the last hit is the lowest
    found  = 1'b0;
    sel_lo = '0;
    sel_hi = '0;
    for (int s = fcst_pkg::RingSize - 1; s >= 0; s--) begin
      if (lane_i[s].all_above || lane_i[s].all_below) begin
        found  = 1'b1;
        sel_lo = lane_i[s].sum_lo;
        sel_hi = lane_i[s].sum_hi;
      end
    end

    score_o     = (pre_o && found) ? (sel_lo + sel_hi) : '0;
    is_corner_o = score_o != '0;
  end

endmodule

[test/fast_corner_segment_test_tb.sv]
// Self-checking bench for fast_corner_segment_test: streams pixel windows, predicts the
// FAST-12 score of every window and checks each returned score in order of arrival.
// Depends on fcst_pkg and the fast_corner_segment_test design.
module fast_corner_segment_test_tb;

  localparam int ArcLen     = 12;
  localparam int CycleLimit = 200000;
  localparam int NumProbes  = 17;
  localparam int MaxIdle    = 19;
  localparam int LongHold   = 80;

  localparam logic [7:0] ThrReset = 8'd10;
  localparam logic [7:0] ThrMax   = 8'd254;
  localparam logic [7:0] ThrBlind = 8'd255;

  typedef enum logic [1:0] {PIX_NONE, PIX_BRIGHT, PIX_DARK} pix_class_e;

  // Same layout as m_axis_tdata[14:0]
  typedef struct packed {
    logic             prescreen;
    logic             corner;
    fcst_pkg::score_t score;
  } corner_result_t;

  // Directed window: ring is base everywhere except where mask marks it
  typedef struct {
    logic [7:0]  center;
    logic [7:0]  base;
    logic [15:0] mask;
    logic [7:0]  mark;
    bit          typed;
    int          want_score;
    logic        want_corner;
    logic        want_pre;
  } probe_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [7:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;

  corner_result_t awaited_scores[$];
  probe_t         probes [NumProbes];
  logic [7:0]     thr_model = ThrReset;
  int             errors = 0;
  int             cycle_count = 0;
  int             stall_left = 0;
  int             hold_left = 0;
  int             hold_req = 0;
  bit             rx_idle = 1'b1;

  fast_corner_segment_test #(
    .ARC_LENGTH(ArcLen)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic corner_result_t fast12_score(input logic [7:0] ctr,
                                                  input logic [127:0] ring,
                                                  input logic [7:0] thr);
    int             diff [fcst_pkg::RingSize];
    pix_class_e     cls [fcst_pkg::RingSize];
    pix_class_e     c;
    int             sum;
    bit             run_ok;
    bit             found;
    corner_result_t res;
    res = '0;
    found = 1'b0;
    for (int k = 0; k < fcst_pkg::RingSize; k++) begin
      diff[k] = int'(ring[8*k +: 8]) - int'(ctr);
      if (diff[k] > int'(thr)) cls[k] = PIX_BRIGHT;
      else if (diff[k] < -int'(thr)) cls[k] = PIX_DARK;
      else cls[k] = PIX_NONE;
    end
    // three cyclically adjacent compass points of one class
    for (int s = 0; s < fcst_pkg::CompassN; s++) begin
      c = cls[fcst_pkg::CompassPos[s]];
      if (c != PIX_NONE && cls[fcst_pkg::CompassPos[(s + 1) % fcst_pkg::CompassN]] == c &&
          cls[fcst_pkg::CompassPos[(s + 2) % fcst_pkg::CompassN]] == c)
        res.prescreen = 1'b1;
    end
    if (res.prescreen) begin
      for (int s = 0; s < fcst_pkg::RingSize; s++) begin
        c = cls[s];
        run_ok = (c != PIX_NONE);
        sum = 0;
        for (int k = 0; k < ArcLen; k++) begin
          if (cls[(s + k) % fcst_pkg::RingSize] != c) run_ok = 1'b0;
          sum += diff[(s + k) % fcst_pkg::RingSize];
        end
        // lowest start wins
        if (run_ok && !found) begin
          res.score = fcst_pkg::score_t'(sum);
          found = 1'b1;
        end
      end
    end
    res.corner = (res.score != 0);
    return res;
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk_i) begin : result_side
    corner_result_t got;
    corner_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = corner_result_t'(m_axis_tdata[14:0]);
      if (awaited_scores.size() == 0) begin
        report($sformatf("result %h with no window pending", m_axis_tdata));
      end else begin
        want = awaited_scores.pop_front();
        if (got.score !== want.score || got.corner !== want.corner ||
            got.prescreen !== want.prescreen || m_axis_tdata[15] !== 1'b0)
          report($sformatf("score exp %0d got %0d, corner exp %b got %b, pre exp %b got %b, pad %b",
                           want.score, got.score, want.corner, got.corner,
                           want.prescreen, got.prescreen, m_axis_tdata[15]));
      end
      stall_left = rx_idle ? $urandom_range(0, MaxIdle) : 0;
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_window(input logic [135:0] word, input int gap,
                             input corner_result_t want);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    awaited_scores.push_back(want);
  endtask

  task automatic wait_drained();
    while (awaited_scores.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [127:0]   ring;
    logic [7:0]     ctr;
    logic [7:0]     new_thr;
    corner_result_t want;
    int             t;
    int             v;
    int             mode;
    int             alen;
    int             first;
    int             n_items;
    bit             up;
    bit             tx_idle;

    //            center base   mask      mark  typed score corner pre
    probes[0]  = '{8'd0,   8'd0,   16'h0000, 8'd0,   1'b1, 0,     1'b0, 1'b0};
    probes[1]  = '{8'd0,   8'd255, 16'h0000, 8'd0,   1'b1, 3060,  1'b1, 1'b1};
    probes[2]  = '{8'd255, 8'd0,   16'h0000, 8'd0,   1'b1, -3060, 1'b1, 1'b1};
    probes[3]  = '{8'd100, 8'd110, 16'h0000, 8'd0,   1'b1, 0,     1'b0, 1'b0};
    probes[4]  = '{8'd100, 8'd111, 16'h0000, 8'd0,   1'b1, 132,   1'b1, 1'b1};
    probes[5]  = '{8'd100, 8'd89,  16'h0000, 8'd0,   1'b1, -132,  1'b1, 1'b1};
    probes[6]  = '{8'd100, 8'd90,  16'h0000, 8'd0,   1'b1, 0,     1'b0, 1'b0};
    probes[7]  = '{8'd100, 8'd100, 16'hFFF0, 8'd200, 1'b1, 1200,  1'b1, 1'b1};
    probes[8]  = '{8'd100, 8'd100, 16'h2220, 8'd200, 1'b1, 0,     1'b0, 1'b1};
    probes[9]  = '{8'd100, 8'd100, 16'h2022, 8'd0,   1'b1, 0,     1'b0, 1'b1};
    probes[10] = '{8'd100, 8'd200, 16'h0F00, 8'd100, 1'b0, 0,     1'b0, 1'b0};
    probes[11] = '{8'd100, 8'd200, 16'h0007, 8'd100, 1'b0, 0,     1'b0, 1'b0};
    probes[12] = '{8'd128, 8'd0,   16'hFF00, 8'd255, 1'b0, 0,     1'b0, 1'b0};
    probes[13] = '{8'd255, 8'd255, 16'h0001, 8'd0,   1'b0, 0,     1'b0, 1'b0};
    probes[14] = '{8'd0,   8'd0,   16'hFFFE, 8'd11,  1'b0, 0,     1'b0, 1'b0};
    probes[15] = '{8'd128, 8'd255, 16'h8421, 8'd0,   1'b0, 0,     1'b0, 1'b0};
    probes[16] = '{8'd1,   8'd0,   16'h0000, 8'd0,   1'b0, 0,     1'b0, 1'b0};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed windows at the reset threshold
    for (int i = 0; i < NumProbes; i++) begin
      for (int k = 0; k < fcst_pkg::RingSize; k++)
        ring[8*k +: 8] = probes[i].mask[k] ? probes[i].mark : probes[i].base;
      if (probes[i].typed) begin
        want.score     = fcst_pkg::score_t'(probes[i].want_score);
        want.corner    = probes[i].want_corner;
        want.prescreen = probes[i].want_pre;
      end else begin
        want = fast12_score(probes[i].center, ring, thr_model);
      end
      send_window({ring, probes[i].center}, $urandom_range(0, MaxIdle), want);
    end
    s_axis_tvalid <= 1'b0;

    for (int ph = 1; ph <= 5; ph++) begin
      // threshold changes only with nothing in flight
      wait_drained();
      case (ph)
        1: begin new_thr = 8'd0;  n_items = 100; tx_idle = 1'b1; rx_idle = 1'b1; end
        2: begin new_thr = ThrMax;   n_items = 80;  tx_idle = 1'b0; rx_idle = 1'b0; end
        3: begin new_thr = ThrBlind; n_items = 40;  tx_idle = 1'b1; rx_idle = 1'b1; end
        4: begin
          new_thr = 8'($urandom_range(1, 253));
          n_items = 100;
          tx_idle = 1'b0;
          rx_idle = 1'b1;
        end
        default: begin
          new_thr = 8'($urandom_range(1, 253));
          n_items = 180;
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
      endcase
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= new_thr;
      @(posedge clk_i);
      cfg_we_i  <= 1'b0;
      thr_model = new_thr;
      // hold the output back while windows keep coming so the pipe backs up
      if (ph == 4) hold_req = LongHold;

      for (int i = 0; i < n_items; i++) begin
        mode = $urandom_range(0, 9);
        ctr  = 8'($urandom_range(0, 255));
        ring = {$urandom, $urandom, $urandom, $urandom};
        t    = thr_model;
        if (mode < 5 && thr_model != ThrBlind) begin
          // one uniform arc of random length and start over a random ring
          up    = $urandom_range(0, 1);
          alen  = $urandom_range(9, fcst_pkg::RingSize);
          first = $urandom_range(0, fcst_pkg::RingSize - 1);
          if (up) ctr = 8'($urandom_range(0, 254 - t));
          else ctr = 8'($urandom_range(t + 1, 255));
          for (int k = 0; k < alen; k++)
            ring[8*((first + k) % fcst_pkg::RingSize) +: 8] =
              up ? 8'($urandom_range(ctr + t + 1, 255)) : 8'($urandom_range(0, ctr - t - 1));
        end else if (mode < 7) begin
          // pixels within one step of the threshold on either side
          for (int k = 0; k < fcst_pkg::RingSize; k++) begin
            v = int'(ctr) + ($urandom_range(0, 1) ? 1 : -1) *
                (t + int'($urandom_range(0, 2)) - 1);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            ring[8*k +: 8] = v[7:0];
          end
        end else if (mode == 7) begin
          ctr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          for (int k = 0; k < fcst_pkg::RingSize; k++)
            ring[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        send_window({ring, ctr}, tx_idle ? $urandom_range(0, MaxIdle) : 0,
                    fast12_score(ctr, ring, thr_model));
      end
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
